FILE: src/filtered_nearest_key_search_defines.svh
// Assertion macros shared by the search block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef FILTERED_NEAREST_KEY_SEARCH_DEFINES_SVH
`define FILTERED_NEAREST_KEY_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNKS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FNKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fnks_pkg.sv
package fnks_pkg;

    localparam int ID_W   = 24;
    localparam int SIZE_W = 24;
    localparam int OP_W   = 2;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic query;
        logic issue;
        logic finish;
    } fnks_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic scan_last;
    } fnks_status_t;

endpackage

FILE: src/filtered_nearest_key_search.sv
// Nearest-key search over a table of (id, size) entries. A request is taken
// when start is high and busy is low. A load appends an entry (dropped when
// the table is full) and a clear empties the table; both leave busy low and
// give no result. A query returns, among entries whose size is at least the
// given minimum, the id closest to the given id, the smaller id on a tie,
// or found low with nearest_id zero if none qualifies. The query reads the
// table through its single read port, one entry per cycle: busy stays high
// from the request through the scan of every stored entry, the drain state
// and the finish state (the finish state alone for an empty table), and
// the result, registered from the finish state, appears with done high for
// exactly one cycle, in the same cycle in which busy falls. The receiver
// cannot stall: the result must be captured in the cycle that done is high.
// A new request may be taken in that same cycle.
`include "filtered_nearest_key_search_defines.svh"

module filtered_nearest_key_search
    import fnks_pkg::*;
    #(
        parameter int MAX_ENTRIES = 256
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              start,
        output logic              busy,
        input  logic [OP_W-1:0]   opcode,
        input  logic [ID_W-1:0]   entry_id,
        input  logic [SIZE_W-1:0] entry_size,
        output logic              done,
        output logic              found,
        output logic [ID_W-1:0]   nearest_id
    );

    fnks_cmd_t    cmd;
    fnks_status_t status;

    // Sequencer.
    fnks_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Table, scan compare and result registers.
    fnks_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .entry_id   (entry_id),
        .entry_size (entry_size),
        .done       (done),
        .found      (found),
        .nearest_id (nearest_id)
    );

    // A query request keeps the block busy in the following cycle.
    `FNKS_ASSERT_NEXT(a_query_busy, start && !busy && (opcode == OP_QUERY), busy, "query not busy")

    // Loads and clears leave the block idle in the following cycle.
    `FNKS_ASSERT_NEXT(a_short_ops, start && !busy && ((opcode == OP_LOAD) || (opcode == OP_CLEAR)), !busy, "load or clear held busy")

    // A result is only presented once the block has gone idle.
    `FNKS_ASSERT_SAME(a_done_idle, done, !busy, "result while busy")

    // A miss reports a zero id, and results never come back to back.
    `FNKS_ASSERT_SAME(a_miss_zero, done && !found, nearest_id == '0, "miss with nonzero id")
    `FNKS_ASSERT_NEXT(a_done_single, done, !done, "result strobe repeated")

endmodule

FILE: src/fnks_ram.sv
module fnks_ram
    #(
        parameter int WIDTH = 48,
        parameter int DEPTH = 256,
        localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fnks_datapath.sv
module fnks_datapath
    import fnks_pkg::*;
    #(
        parameter int MAX_ENTRIES = 256
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  fnks_cmd_t         cmd,
        output fnks_status_t      status,
        input  logic [ID_W-1:0]   entry_id,
        input  logic [SIZE_W-1:0] entry_size,
        output logic              done,
        output logic              found,
        output logic [ID_W-1:0]   nearest_id
    );

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W = ID_W + SIZE_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  scan_next;
    logic [CNT_W-1:0]  scan_inc;
    logic              issued_reg;
    logic [ID_W-1:0]   key_reg;
    logic [SIZE_W-1:0] min_reg;
    logic              hit_reg;
    logic              hit_next;
    logic [ID_W-1:0]   best_id_reg;
    logic [ID_W-1:0]   best_id_next;
    logic [ID_W-1:0]   best_d_reg;
    logic [ID_W-1:0]   best_d_next;
    logic              done_reg;
    logic              found_reg;
    logic [ID_W-1:0]   nearest_id_reg;

    logic              full;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic [ID_W-1:0]   cand_id;
    logic [SIZE_W-1:0] cand_size;
    logic [ID_W-1:0]   cand_d;
    logic              take;

    // Entry table: id in the upper half of each word, size in the lower half.
    assign full   = (count_reg == CNT_W'(MAX_ENTRIES));
    assign ram_we = cmd.load && !full;

    fnks_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({entry_id, entry_size}),
        .re    (cmd.issue),
        .raddr (scan_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Entry count and scan pointer.
    assign scan_inc = scan_reg + CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (ram_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        scan_next = scan_reg;
        if (cmd.query)
        begin
            scan_next = '0;
        end
        else if (cmd.issue)
        begin
            scan_next = scan_inc;
        end
    end

    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (scan_inc == count_reg);

    // Compare the entry read in the previous cycle against the best so far.
    assign cand_id   = ram_rdata[WORD_W-1:SIZE_W];
    assign cand_size = ram_rdata[SIZE_W-1:0];
    assign cand_d    = (cand_id >= key_reg) ? (cand_id - key_reg) : (key_reg - cand_id);
    assign take      = issued_reg && (cand_size >= min_reg) &&
                       (!hit_reg || (cand_d < best_d_reg) ||
                        ((cand_d == best_d_reg) && (cand_id < best_id_reg)));

    always_comb
    begin
        hit_next     = hit_reg;
        best_id_next = best_id_reg;
        best_d_next  = best_d_reg;
        if (cmd.query)
        begin
            hit_next = 1'b0;
        end
        else if (take)
        begin
            hit_next     = 1'b1;
            best_id_next = cand_id;
            best_d_next  = cand_d;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= '0;
            issued_reg <= 1'b0;
            hit_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            issued_reg <= cmd.issue;
            hit_reg    <= hit_next;
            done_reg   <= cmd.finish;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            key_reg <= entry_id;
            min_reg <= entry_size;
        end
        best_id_reg <= best_id_next;
        best_d_reg  <= best_d_next;
        if (cmd.finish)
        begin
            found_reg      <= hit_reg;
            nearest_id_reg <= hit_reg ? best_id_reg : '0;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign nearest_id = nearest_id_reg;

endmodule

FILE: src/fnks_ctrl.sv
module fnks_ctrl
    import fnks_pkg::*;
    (
        input  logic            clk,
        input  logic            rst_n,
        input  logic            start,
        input  logic [OP_W-1:0] opcode,
        input  fnks_status_t    status,
        output fnks_cmd_t       cmd,
        output logic            busy
    );

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    // Commands and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = status.empty ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered busy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

FILE: test/nearest_search_checker.sv
`timescale 1ns / 100ps

// Watches the request and result ports of the search block. It keeps its own
// copy of the entry table, works out the answer to each accepted query, and
// compares every result with the oldest answer still owed.
module nearest_search_checker
    import fnks_pkg::*;
    #(
        parameter int MAX_ENTRIES = 256
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              start,
        input  logic              busy,
        input  logic [OP_W-1:0]   opcode,
        input  logic [ID_W-1:0]   entry_id,
        input  logic [SIZE_W-1:0] entry_size,
        input  logic              done,
        input  logic              found,
        input  logic [ID_W-1:0]   nearest_id,
        output int                mismatches,
        output int                answers_owed
    );

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] id;
    } answer_t;

    logic [ID_W-1:0]   shadow_ids   [MAX_ENTRIES];
    logic [SIZE_W-1:0] shadow_sizes [MAX_ENTRIES];
    int                shadow_count;
    answer_t           expected_answers [$];

    // Nearest id among entries large enough; the smaller id wins a tie.
    function automatic answer_t nearest_match(input logic [ID_W-1:0] want_id,
                                              input logic [SIZE_W-1:0] min_size);
        answer_t         best;
        logic [ID_W-1:0] best_gap;
        logic [ID_W-1:0] gap;
        best     = '0;
        best_gap = '0;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_sizes[i] >= min_size)
            begin
                gap = (shadow_ids[i] >= want_id) ? shadow_ids[i] - want_id
                                                 : want_id - shadow_ids[i];
                if (!best.found || gap < best_gap ||
                    (gap == best_gap && shadow_ids[i] < best.id))
                begin
                    best.found = 1'b1;
                    best.id    = shadow_ids[i];
                    best_gap   = gap;
                end
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input answer_t want,
                                   input answer_t got);
        mismatches++;
        $display("%0t: %s: expected found=%0b id=%h, got found=%0b id=%h",
                 $time, what, want.found, want.id, got.found, got.id);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_answers.delete();
            mismatches   = 0;
            answers_owed = 0;
        end
        else
        begin
            // Results are checked before the request of the same edge is taken in,
            // since a query accepted now answers only in a later cycle.
            if (done === 1'b1)
            begin
                got.found = found;
                got.id    = nearest_id;
                if (expected_answers.size() == 0)
                    report_mismatch("result with no query waiting", '0, got);
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("found flag", want, got);
                    if (got.id !== want.id)
                        report_mismatch("nearest id", want, got);
                end
            end

            // Track the table and queue the answer of each accepted query.
            if (start && !busy)
            begin
                case (opcode)
                    OP_LOAD:
                    begin
                        if (shadow_count < MAX_ENTRIES)
                        begin
                            shadow_ids[shadow_count]   = entry_id;
                            shadow_sizes[shadow_count] = entry_size;
                            shadow_count++;
                        end
                    end
                    OP_CLEAR: shadow_count = 0;
                    OP_QUERY: expected_answers.push_back(nearest_match(entry_id, entry_size));
                    default: ;
                endcase
            end
            answers_owed = expected_answers.size();
        end
    end

endmodule

FILE: test/filtered_nearest_key_search_tb.sv
`timescale 1ns / 100ps

module filtered_nearest_key_search_tb;
    import fnks_pkg::*;

    localparam int MAX_ENTRIES  = 256;
    localparam int ITEM_TARGET  = 1400;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic [OP_W-1:0]   opcode     = OP_LOAD;
    logic [ID_W-1:0]   entry_id   = '0;
    logic [SIZE_W-1:0] entry_size = '0;
    logic              busy;
    logic              done;
    logic              found;
    logic [ID_W-1:0]   nearest_id;

    int mismatches;
    int answers_owed;
    int cycle_count   = 0;
    int requests_sent = 0;
    bit idle_enabled  = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    filtered_nearest_key_search #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .entry_id   (entry_id),
        .entry_size (entry_size),
        .done       (done),
        .found      (found),
        .nearest_id (nearest_id)
    );

    nearest_search_checker #(.MAX_ENTRIES(MAX_ENTRIES)) search_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .entry_id     (entry_id),
        .entry_size   (entry_size),
        .done         (done),
        .found        (found),
        .nearest_id   (nearest_id),
        .mismatches   (mismatches),
        .answers_owed (answers_owed)
    );

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Start drops
    // now and then while waiting, so gaps land in every phase of a scan.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [SIZE_W-1:0] size_val);
        @(negedge clk);
        opcode     <= op;
        entry_id   <= id;
        entry_size <= size_val;
        start      <= (idle_enabled && $urandom_range(0, 99) < 10) ? 1'b0 : 1'b1;
        forever
        begin
            @(posedge clk);
            if (start && !busy)
                break;
            @(negedge clk);
            start <= (idle_enabled && $urandom_range(0, 99) < 10) ? 1'b0 : 1'b1;
        end
        if (op != OP_UNUSED)
            requests_sent++;
    endtask

    // Stop sending and wait until every owed answer has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (answers_owed != 0)
            @(negedge clk);
    endtask

    // Ids mostly cluster around a center so that ties and near misses happen.
    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] center);
        logic [31:0] offset;
        offset = $urandom_range(0, 40);
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom());
        return center + ID_W'(offset) - ID_W'(20);
    endfunction

    // Sizes mostly small so that the minimum-size filter rejects some entries.
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom());
            default: return SIZE_W'($urandom_range(0, 15));
        endcase
    endfunction

    // One block of traffic: usually a table rebuild followed by queries,
    // sometimes raw noise with any opcode and any field values.
    task automatic run_phase(input bit fill_table);
        logic [ID_W-1:0] center;
        int              loads;
        center = ID_W'($urandom());
        if (!fill_table && $urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(4, 20))
                send_request(OP_W'($urandom_range(0, 3)), ID_W'($urandom()),
                             SIZE_W'($urandom()));
            return;
        end
        if (fill_table || $urandom_range(0, 3) != 0)
            send_request(OP_CLEAR, ID_W'($urandom()), SIZE_W'($urandom()));
        if (fill_table)
            loads = MAX_ENTRIES + $urandom_range(1, 8);
        else if ($urandom_range(0, 7) == 0)
            loads = $urandom_range(17, 64);
        else
            loads = $urandom_range(0, 16);
        repeat (loads)
            send_request(OP_LOAD, pick_id(center), pick_size());
        repeat ($urandom_range(2, 10))
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_LOAD, pick_id(center), pick_size());
            send_request(OP_QUERY, pick_id(center), pick_size());
        end
    endtask

    initial
    begin
        int phase_no;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, unused opcode, field extremes, ties,
        // size filter, and a clear.
        send_request(OP_QUERY, 24'h000000, 24'h000000);
        send_request(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OP_LOAD, 24'h000000, 24'h000000);
        send_request(OP_LOAD, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OP_LOAD, 24'h000100, 24'h000050);
        send_request(OP_LOAD, 24'h000200, 24'h000050);
        send_request(OP_QUERY, 24'h000180, 24'h000000);
        send_request(OP_QUERY, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OP_QUERY, 24'h000000, 24'h000000);
        send_request(OP_QUERY, 24'h000000, 24'hFFFFFF);
        send_request(OP_QUERY, 24'h000180, 24'h000051);
        send_request(OP_UNUSED, 24'h000180, 24'h000000);
        send_request(OP_QUERY, 24'h000180, 24'h000000);
        send_request(OP_CLEAR, 24'h000000, 24'h000000);
        send_request(OP_QUERY, 24'h000180, 24'h000000);
        send_request(OP_LOAD, 24'h000007, 24'h000003);
        send_request(OP_QUERY, 24'h000007, 24'h000004);
        send_request(OP_QUERY, 24'h000007, 24'h000003);
        send_request(OP_LOAD, 24'h00000B, 24'h000003);
        send_request(OP_QUERY, 24'h000009, 24'h000000);
        wait_drained();

        // Random part, with a stretch of back-to-back requests in the middle
        // and an occasional full drain between phases.
        phase_no = 0;
        while (requests_sent < ITEM_TARGET)
        begin
            idle_enabled = !(requests_sent >= 500 && requests_sent < 800);
            run_phase(phase_no % 30 == 3);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && answers_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filtered_nearest_key_search.f
+incdir+src
src/fnks_pkg.sv
src/fnks_ram.sv
src/fnks_datapath.sv
src/fnks_ctrl.sv
src/filtered_nearest_key_search.sv
test/nearest_search_checker.sv
test/filtered_nearest_key_search_tb.sv
